/* hw/rtl/irl_pkg.sv */
// Shared types and constants for the indexed record list.
// Used by irl_ctrl, irl_rec_store and indexed_record_list; no dependencies.
package irl_pkg;

  // Default sizes
  localparam int DEF_CAPACITY     = 64;
  localparam int DEF_RECORD_WIDTH = 32;

  // Fixed port widths
  localparam int OP_W      = 3;
  localparam int POS_W     = 6;
  localparam int IN_REC_W  = 32;
  localparam int OUT_REC_W = 32;
  localparam int CNT_OUT_W = 7;
  localparam int STAT_W    = 2;

  // Opcodes
  localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_APPEND    = 3'd1;
  localparam logic [OP_W-1:0] OP_READ      = 3'd2;
  localparam logic [OP_W-1:0] OP_WRITE     = 3'd3;
  localparam logic [OP_W-1:0] OP_DELETE    = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR     = 3'd5;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_ALLOC,
    S_POST,
    S_DEL_MID,
    S_DEL_FREE
  } state_t;

  // Record memory port controls
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } rec_ctl_t;

  // Finished transaction: status and where the record comes from
  typedef struct packed {
    logic              valid;
    logic [STAT_W-1:0] status;
    logic              from_mem;
    logic              from_in;
  } result_t;

endpackage

/* hw/rtl/irl_rec_store.sv */
// Record memory of the indexed record list: one write and one registered read port.
// Depends on irl_pkg.
module irl_rec_store
  import irl_pkg::*;
#(
  parameter int CAPACITY     = DEF_CAPACITY,
  parameter int RECORD_WIDTH = DEF_RECORD_WIDTH,
  localparam int SW          = $clog2(CAPACITY)
) (
  input  logic                    clk,
  input  rec_ctl_t                ctl,
  input  logic [SW-1:0]           raddr,
  input  logic [SW-1:0]           waddr,
  input  logic [RECORD_WIDTH-1:0] wdata,
  output logic [RECORD_WIDTH-1:0] rdata
);

  logic [RECORD_WIDTH-1:0] mem [CAPACITY];

  // Write port
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds until the next enabled read
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/irl_ctrl.sv */
// Sequencer of the indexed record list: list pointers, free chain and link memory.
// Depends on irl_pkg; drives the record memory in irl_rec_store.
module irl_ctrl
  import irl_pkg::*;
#(
  parameter int CAPACITY     = DEF_CAPACITY,
  parameter int RECORD_WIDTH = DEF_RECORD_WIDTH,
  localparam int SW          = $clog2(CAPACITY),
  localparam int CW          = $clog2(CAPACITY + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [OP_W-1:0]         opcode,
  input  logic [POS_W-1:0]        position,
  input  logic [IN_REC_W-1:0]     record_in,
  output logic                    busy,
  output rec_ctl_t                rec_ctl,
  output logic [SW-1:0]           rec_raddr,
  output logic [SW-1:0]           rec_waddr,
  output logic [RECORD_WIDTH-1:0] rec_wdata,
  output result_t                 res,
  output logic [CW-1:0]           count
);

  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  state_t state, state_next;

  logic [OP_W-1:0]         op, op_next;
  logic [POS_W-1:0]        pos, pos_next;
  logic [RECORD_WIDTH-1:0] val, val_next;
  logic [SW-1:0]           first, first_next;
  logic [SW-1:0]           last, last_next;
  logic [SW-1:0]           cur, cur_next;
  logic [SW-1:0]           del_slot, del_slot_next;
  logic [SW-1:0]           free_head, free_head_next;
  logic [CW-1:0]           count_next;
  logic [CW-1:0]           fresh, fresh_next;
  logic [CW-1:0]           free_len, free_len_next;
  logic [POS_W-1:0]        rem, rem_next;

  // Link memory
  logic [SW-1:0] link_mem [CAPACITY];
  logic [SW-1:0] link_q;
  logic          link_we;
  logic [SW-1:0] link_waddr;
  logic [SW-1:0] link_wdata;
  logic [SW-1:0] mem_raddr;

  logic          full;
  logic          out_of_range;
  logic [SW-1:0] alloc_slot;
  logic [POS_W-1:0] steps;

  assign busy      = (state != S_IDLE);
  assign rec_raddr = mem_raddr;
  assign rec_wdata = val;

  assign full         = (count == CW'(CAPACITY));
  assign out_of_range = (CMPW'(position) >= CMPW'(count));
  // Reuse a freed slot first, else take the next never-used one
  assign alloc_slot   = (free_len != '0) ? free_head : fresh[SW-1:0];
  assign steps        = ((opcode == OP_DELETE) && (position != '0)) ?
                        (position - POS_W'(1)) : position;

  // Link memory ports
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
  end

  always_ff @(posedge clk) begin
    link_q <= link_mem[mem_raddr];
  end

  // State and pointer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      first     <= '0;
      last      <= '0;
      count     <= '0;
      fresh     <= '0;
      free_len  <= '0;
      free_head <= '0;
    end else begin
      state     <= state_next;
      first     <= first_next;
      last      <= last_next;
      count     <= count_next;
      fresh     <= fresh_next;
      free_len  <= free_len_next;
      free_head <= free_head_next;
    end
  end

  // Transaction payload and walk registers
  always_ff @(posedge clk) begin
    op       <= op_next;
    pos      <= pos_next;
    val      <= val_next;
    cur      <= cur_next;
    del_slot <= del_slot_next;
    rem      <= rem_next;
  end

  // Next state and memory controls
  always_comb begin
    state_next     = state;
    op_next        = op;
    pos_next       = pos;
    val_next       = val;
    first_next     = first;
    last_next      = last;
    cur_next       = cur;
    del_slot_next  = del_slot;
    free_head_next = free_head;
    count_next     = count;
    fresh_next     = fresh;
    free_len_next  = free_len;
    rem_next       = rem;
    mem_raddr      = cur;
    rec_ctl        = '0;
    rec_waddr      = cur;
    link_we        = 1'b0;
    link_waddr     = cur;
    link_wdata     = first;
    res            = '0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          op_next  = opcode;
          pos_next = position;
          val_next = RECORD_WIDTH'(record_in);
          unique case (opcode) inside
            OP_INS_FRONT, OP_APPEND: begin
              if (full) begin
                res.valid  = 1'b1;
                res.status = STAT_FULL;
              end else begin
                // fetch the successor of the free-chain head
                mem_raddr  = free_head;
                state_next = S_ALLOC;
              end
            end
            OP_READ, OP_WRITE, OP_DELETE: begin
              if (out_of_range) begin
                res.valid  = 1'b1;
                res.status = STAT_RANGE;
              end else begin
                mem_raddr     = first;
                rec_ctl.rd_en = 1'b1;
                cur_next      = first;
                rem_next      = steps;
                state_next    = (steps == '0) ? S_POST : S_WALK;
              end
            end
            OP_CLEAR: begin
              count_next    = '0;
              fresh_next    = '0;
              free_len_next = '0;
              first_next    = '0;
              last_next     = '0;
              res.valid     = 1'b1;
              res.status    = STAT_OK;
            end
            default: begin
              res.valid  = 1'b1;
              res.status = STAT_OK;
            end
          endcase
        end
      end

      // One link per cycle; the read of the next link is issued from link_q
      S_WALK: begin
        cur_next      = link_q;
        mem_raddr     = link_q;
        rec_ctl.rd_en = 1'b1;
        rem_next      = rem - POS_W'(1);
        if (rem == POS_W'(1)) begin
          state_next = S_POST;
        end
      end

      // Take a slot and link it in at the front or the end
      S_ALLOC: begin
        if (free_len != '0) begin
          free_head_next = link_q;
          free_len_next  = free_len - CW'(1);
        end else begin
          fresh_next = fresh + CW'(1);
        end
        rec_ctl.wr_en = 1'b1;
        rec_waddr     = alloc_slot;
        if (op == OP_INS_FRONT) begin
          link_we    = 1'b1;
          link_waddr = alloc_slot;
          link_wdata = first;
          first_next = alloc_slot;
          if (count == '0) begin
            last_next = alloc_slot;
          end
        end else begin
          if (count != '0) begin
            link_we    = 1'b1;
            link_waddr = last;
            link_wdata = alloc_slot;
          end else begin
            first_next = alloc_slot;
          end
          last_next = alloc_slot;
        end
        count_next   = count + CW'(1);
        res.valid    = 1'b1;
        res.status   = STAT_OK;
        res.from_in  = 1'b1;
        state_next   = S_IDLE;
      end

      // cur is the target (or its predecessor for a delete past the head);
      // link_q and the record read hold that slot's contents
      S_POST: begin
        state_next = S_IDLE;
        case (op)
          OP_READ: begin
            res.valid    = 1'b1;
            res.status   = STAT_OK;
            res.from_mem = 1'b1;
          end
          OP_WRITE: begin
            rec_ctl.wr_en = 1'b1;
            rec_waddr     = cur;
            res.valid     = 1'b1;
            res.status    = STAT_OK;
            res.from_in   = 1'b1;
          end
          OP_DELETE: begin
            if (pos == '0) begin
              // unlink the head and push it on the free chain
              first_next     = link_q;
              link_we        = 1'b1;
              link_waddr     = cur;
              link_wdata     = free_head;
              free_head_next = cur;
              free_len_next  = free_len + CW'(1);
              count_next     = count - CW'(1);
              if (count == CW'(1)) begin
                first_next = '0;
                last_next  = '0;
              end
              res.valid    = 1'b1;
              res.status   = STAT_OK;
              res.from_mem = 1'b1;
            end else begin
              // read the victim's link and record
              del_slot_next = link_q;
              mem_raddr     = link_q;
              rec_ctl.rd_en = 1'b1;
              state_next    = S_DEL_MID;
            end
          end
          default: begin
          end
        endcase
      end

      // Bypass the victim: predecessor takes the victim's successor
      S_DEL_MID: begin
        link_we    = 1'b1;
        link_waddr = cur;
        link_wdata = link_q;
        if (del_slot == last) begin
          last_next = cur;
        end
        state_next = S_DEL_FREE;
      end

      // Return the victim slot to the free chain
      S_DEL_FREE: begin
        link_we        = 1'b1;
        link_waddr     = del_slot;
        link_wdata     = free_head;
        free_head_next = del_slot;
        free_len_next  = free_len + CW'(1);
        count_next     = count - CW'(1);
        res.valid      = 1'b1;
        res.status     = STAT_OK;
        res.from_mem   = 1'b1;
        state_next     = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/indexed_record_list.sv */
// Indexed record list top level: sequencer, record memory and result register.
// Depends on irl_pkg, irl_ctrl and irl_rec_store.
//
// A bounded ordered list of records kept as a linked chain in a link memory
// and a record memory, both with registered reads. A transaction is
// taken when start is high and busy is low; its single result appears on
// status, record_out and entry_count for one cycle with done high and must
// be captured then, as the receiver cannot stall it. Clear, unused opcodes
// and rejected requests finish in the accepting state; insert and append
// pass through the allocation state; read and overwrite walk the chain to
// the position; delete walks to the target at position zero, else to its
// predecessor, and then bypasses and frees the victim. The link walk, one
// link memory read per cycle, sets how long a transaction takes, so it
// grows with the position. busy drops in the cycle that shows done, so the
// next transaction can be taken then. No clearing pass after reset is needed.
module indexed_record_list
  import irl_pkg::*;
#(
  parameter int CAPACITY     = DEF_CAPACITY,
  parameter int RECORD_WIDTH = DEF_RECORD_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [OP_W-1:0]      opcode,
  input  logic [POS_W-1:0]     position,
  input  logic [IN_REC_W-1:0]  record_in,
  output logic                 done,
  output logic [STAT_W-1:0]    status,
  output logic [OUT_REC_W-1:0] record_out,
  output logic [CNT_OUT_W-1:0] entry_count
);

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  rec_ctl_t                rec_ctl;
  result_t                 res;
  logic [SW-1:0]           rec_raddr;
  logic [SW-1:0]           rec_waddr;
  logic [RECORD_WIDTH-1:0] rec_wdata;
  logic [RECORD_WIDTH-1:0] rec_rdata;
  logic [RECORD_WIDTH-1:0] rec_sel;
  logic [CW-1:0]           count;

  irl_ctrl #(
    .CAPACITY     (CAPACITY),
    .RECORD_WIDTH (RECORD_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .opcode    (opcode),
    .position  (position),
    .record_in (record_in),
    .busy      (busy),
    .rec_ctl   (rec_ctl),
    .rec_raddr (rec_raddr),
    .rec_waddr (rec_waddr),
    .rec_wdata (rec_wdata),
    .res       (res),
    .count     (count)
  );

  irl_rec_store #(
    .CAPACITY     (CAPACITY),
    .RECORD_WIDTH (RECORD_WIDTH)
  ) u_rec_store (
    .clk   (clk),
    .ctl   (rec_ctl),
    .raddr (rec_raddr),
    .waddr (rec_waddr),
    .wdata (rec_wdata),
    .rdata (rec_rdata)
  );

  // Record of the finished transaction; zero unless the status is ok
  always_comb begin
    rec_sel = '0;
    if (res.from_mem) begin
      rec_sel = rec_rdata;
    end else if (res.from_in) begin
      rec_sel = rec_wdata;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      status     <= res.status;
      record_out <= OUT_REC_W'(rec_sel);
    end
  end

  // Count register already holds the post-transaction value while done is high
  assign entry_count = CNT_OUT_W'(count);

endmodule

/* bench/tb.sv */
// Self-checking testbench for indexed_record_list: directed and random list traffic.
// Depends on irl_pkg and indexed_record_list. A queue-based shadow list predicts
// every result.
`timescale 1ns / 100ps

module tb;
  import irl_pkg::*;

  localparam int CAP         = DEF_CAPACITY;
  localparam int N_RANDOM    = 1525;
  localparam int QUIET_TAIL  = 200;
  localparam int CYCLE_LIMIT = 700000;
  localparam int DRAIN_WAIT  = 80;

  // Opcodes the block does not use
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

  typedef enum {FILLING, DRAINING} trend_t;

  typedef struct packed {
    logic [STAT_W-1:0]    status;
    logic [OUT_REC_W-1:0] rec;
    logic [CNT_OUT_W-1:0] cnt;
  } list_outcome_t;

  // Shadow of the list contents plus the outcomes still to arrive
  class record_list_tracker;
    logic [IN_REC_W-1:0] shadow_list[$];
    list_outcome_t       pending_outcomes[$];
    int errors    = 0;
    int accepted  = 0;
    int checked   = 0;
    int full_hits = 0;
    int range_hits = 0;
    int peak      = 0;

    function int depth();
      return shadow_list.size();
    endfunction

    function int pending();
      return pending_outcomes.size();
    endfunction

    // Apply one accepted transaction to the shadow list and queue its outcome
    function void note_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                               logic [IN_REC_W-1:0] rec);
      list_outcome_t o;
      o.status = STAT_OK;
      o.rec    = '0;
      accepted++;
      case (op)
        OP_INS_FRONT, OP_APPEND: begin
          if (shadow_list.size() >= CAP) begin
            o.status = STAT_FULL;
            full_hits++;
          end else begin
            if (op == OP_INS_FRONT) shadow_list.push_front(rec);
            else shadow_list.push_back(rec);
            o.rec = rec;
          end
        end
        OP_READ, OP_WRITE: begin
          if (int'(pos) >= shadow_list.size()) begin
            o.status = STAT_RANGE;
            range_hits++;
          end else begin
            if (op == OP_WRITE) shadow_list[pos] = rec;
            o.rec = shadow_list[pos];
          end
        end
        OP_DELETE: begin
          if (int'(pos) >= shadow_list.size()) begin
            o.status = STAT_RANGE;
            range_hits++;
          end else begin
            o.rec = shadow_list[pos];
            shadow_list.delete(int'(pos));
          end
        end
        OP_CLEAR: shadow_list.delete();
        default: ;
      endcase
      o.cnt = CNT_OUT_W'(shadow_list.size());
      if (shadow_list.size() > peak) peak = shadow_list.size();
      pending_outcomes.push_back(o);
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
      errors++;
    endfunction

    // Compare one result with the oldest queued outcome
    function void check_outcome(logic [STAT_W-1:0] st, logic [OUT_REC_W-1:0] rec,
                                logic [CNT_OUT_W-1:0] cnt);
      list_outcome_t o;
      if (pending_outcomes.size() == 0) begin
        $display("%0t: result with none outstanding: expected nothing, actual %0h/%0h/%0h",
                 $time, st, rec, cnt);
        errors++;
        return;
      end
      o = pending_outcomes.pop_front();
      checked++;
      if (st !== o.status) report("status", 32'(o.status), 32'(st));
      if (rec !== o.rec) report("record_out", o.rec, rec);
      if (cnt !== o.cnt) report("entry_count", 32'(o.cnt), 32'(cnt));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic [OP_W-1:0]      opcode = '0;
  logic [POS_W-1:0]     position = '0;
  logic [IN_REC_W-1:0]  record_in = '0;
  logic                 busy;
  logic                 done;
  logic [STAT_W-1:0]    status;
  logic [OUT_REC_W-1:0] record_out;
  logic [CNT_OUT_W-1:0] entry_count;

  int cycle_count = 0;
  record_list_tracker tracker = new();

  indexed_record_list dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .opcode      (opcode),
    .position    (position),
    .record_in   (record_in),
    .done        (done),
    .status      (status),
    .record_out  (record_out),
    .entry_count (entry_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Results are valid for one cycle only; capture each one
  always @(posedge clk) begin
    if (!rst && done) begin
      tracker.check_outcome(status, record_out, entry_count);
    end
  end

  // Issue one transaction after an optional idle burst
  task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                              input logic [IN_REC_W-1:0] rec, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    opcode    <= op;
    position  <= pos;
    record_in <= rec;
    do @(posedge clk); while (busy);
    tracker.note_request(op, pos, rec);
  endtask

  function automatic int idle_gap(bit quiet);
    if (quiet) return 0;
    if ($urandom_range(0, 99) < 25) return $urandom_range(1, 18);
    return 0;
  endfunction

  // Mostly valid positions, with the boundary and out-of-range cases mixed in
  function automatic logic [POS_W-1:0] pick_position(int depth);
    int r;
    r = $urandom_range(0, 99);
    if (depth == 0 || r < 15) return POS_W'($urandom_range(0, 63));
    if (r < 25) return POS_W'(depth - 1);
    if (r < 32 && depth < CAP) return POS_W'(depth);
    return POS_W'($urandom_range(0, depth - 1));
  endfunction

  function automatic logic [IN_REC_W-1:0] pick_record();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  function automatic logic [OP_W-1:0] pick_opcode(trend_t trend);
    int r;
    logic [OP_W-1:0] grow;
    r = $urandom_range(0, 999);
    grow = $urandom_range(0, 1) ? OP_APPEND : OP_INS_FRONT;
    if (r < 5) return OP_CLEAR;
    if (r < 10) return OP_SPARE_A;
    if (r < 15) return OP_SPARE_B;
    if (trend == FILLING) begin
      if (r < 640) return grow;
      if (r < 760) return OP_READ;
      if (r < 880) return OP_WRITE;
      return OP_DELETE;
    end
    if (r < 200) return grow;
    if (r < 350) return OP_READ;
    if (r < 500) return OP_WRITE;
    return OP_DELETE;
  endfunction

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("%0t: timeout with %0d results outstanding", $time, tracker.pending());
    $display("** indexed_record_list: FAILED **");
    $finish;
  end

  initial begin
    trend_t trend;
    bit quiet;
    trend = FILLING;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty-list corner cases
    send_request(OP_CLEAR,     6'd0,  32'h0000_0000, idle_gap(0));
    send_request(OP_READ,      6'd0,  32'h0000_0000, idle_gap(0));
    send_request(OP_DELETE,    6'd0,  32'h0000_0000, idle_gap(0));
    send_request(OP_WRITE,     6'd0,  32'hFFFF_FFFF, idle_gap(0));
    send_request(OP_SPARE_A,   6'd63, 32'hFFFF_FFFF, idle_gap(0));
    send_request(OP_SPARE_B,   6'd0,  32'h1234_5678, idle_gap(0));
    // Build a four-entry list from both ends
    send_request(OP_INS_FRONT, 6'd0,  32'hFFFF_FFFF, idle_gap(0));
    send_request(OP_APPEND,    6'd0,  32'h0000_0000, idle_gap(0));
    send_request(OP_INS_FRONT, 6'd63, 32'hA5A5_A5A5, idle_gap(0));
    send_request(OP_APPEND,    6'd0,  32'h5A5A_5A5A, idle_gap(0));
    for (int p = 0; p < 4; p++) begin
      send_request(OP_READ, POS_W'(p), 32'h0, idle_gap(0));
    end
    send_request(OP_READ,      6'd4,  32'h0, idle_gap(0));
    send_request(OP_READ,      6'd63, 32'h0, idle_gap(0));
    send_request(OP_WRITE,     6'd3,  32'hFFFF_FFFF, idle_gap(0));
    send_request(OP_WRITE,     6'd0,  32'h0000_0000, idle_gap(0));
    // Delete the tail, then append to check the tail pointer moved back
    send_request(OP_DELETE,    6'd3,  32'h0, idle_gap(0));
    send_request(OP_APPEND,    6'd0,  32'h1234_5678, idle_gap(0));
    send_request(OP_DELETE,    6'd1,  32'h0, idle_gap(0));
    send_request(OP_DELETE,    6'd0,  32'h0, idle_gap(0));
    send_request(OP_READ,      6'd1,  32'h0, idle_gap(0));
    send_request(OP_CLEAR,     6'd0,  32'h0, idle_gap(0));
    send_request(OP_APPEND,    6'd0,  32'hDEAD_BEEF, idle_gap(0));
    send_request(OP_READ,      6'd0,  32'h0, idle_gap(0));

    // Random: alternate fill and drain trends so the list runs full and empty
    for (int i = 0; i < N_RANDOM; i++) begin
      if (trend == FILLING && tracker.depth() == CAP && $urandom_range(0, 7) == 0) begin
        trend = DRAINING;
      end else if (trend == DRAINING && tracker.depth() == 0 &&
                   $urandom_range(0, 3) == 0) begin
        trend = FILLING;
      end
      quiet = (i >= N_RANDOM - QUIET_TAIL);
      send_request(pick_opcode(trend), pick_position(tracker.depth()), pick_record(),
                   idle_gap(quiet));
    end

    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Ran %0d transactions, %0d results checked, peak list depth %0d.",
             tracker.accepted, tracker.checked, tracker.peak);
    $display("Rejections seen: %0d list full, %0d out of range.",
             tracker.full_hits, tracker.range_hits);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("** indexed_record_list: PASSED **");
    end else begin
      $display("** indexed_record_list: FAILED **");
    end
    $finish;
  end

endmodule
